// File: src/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_AT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("check failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error("check failed");
`else
`define ASSERT_AT(lbl, clk, rstn, prop)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: src/d2q9_pkg.sv
package d2q9_pkg;

    localparam int WORD_W        = 20;
    localparam int NPOP          = 9;
    localparam int RATE_W        = 17;
    localparam int RATE_FRAC     = 16;
    localparam logic [RATE_W-1:0] RATE_RESET = 17'd113620;
    localparam int FRAC_BITS_DEF = 16;
    localparam int SUM_W         = 24;
    localparam int JW            = 24;
    localparam int UU_W          = 2 * WORD_W;
    localparam int DIV_LAT       = WORD_W + 2;
    localparam int LANE_LAT      = 9;

    // lattice directions and weight shifts (weights 16, 4, 1 in units of 1/36)
    localparam int DIR_X [NPOP] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
    localparam int DIR_Y [NPOP] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
    localparam int WT_SH [NPOP] = '{4, 2, 2, 2, 2, 0, 0, 0, 0};

    typedef logic signed [WORD_W-1:0] word_t;

    typedef struct packed {
        word_t [NPOP-1:0] post;
        word_t            density;
        word_t            vel_x;
        word_t            vel_y;
    } out_item_t;

    typedef struct packed {
        logic push;
        logic take;
    } obuf_ctl_t;

    typedef struct packed {
        logic full;
        logic avail;
    } obuf_sts_t;

    // clamp to the signed word range
    function automatic word_t sat_word(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (WORD_W - 1)) - 64'sd1;
        lo = -(64'sd1 <<< (WORD_W - 1));
        if (v > hi)
            return hi[WORD_W-1:0];
        else if (v < lo)
            return lo[WORD_W-1:0];
        else
            return v[WORD_W-1:0];
    endfunction

endpackage

// File: src/d2q9_in_if.sv
interface d2q9_in_if;
    import d2q9_pkg::*;

    logic  valid;
    logic  ready;
    word_t pop_rest;
    word_t pop_east;
    word_t pop_north;
    word_t pop_west;
    word_t pop_south;
    word_t pop_northeast;
    word_t pop_northwest;
    word_t pop_southwest;
    word_t pop_southeast;

    modport source (
        output valid, pop_rest, pop_east, pop_north, pop_west, pop_south,
        pop_northeast, pop_northwest, pop_southwest, pop_southeast,
        input  ready
    );
    modport sink (
        input  valid, pop_rest, pop_east, pop_north, pop_west, pop_south,
        pop_northeast, pop_northwest, pop_southwest, pop_southeast,
        output ready
    );
endinterface

// File: src/d2q9_out_if.sv
interface d2q9_out_if;
    import d2q9_pkg::*;

    logic  valid;
    logic  ready;
    word_t post_rest;
    word_t post_east;
    word_t post_north;
    word_t post_west;
    word_t post_south;
    word_t post_northeast;
    word_t post_northwest;
    word_t post_southwest;
    word_t post_southeast;
    word_t density;
    word_t vel_x;
    word_t vel_y;

    modport source (
        output valid, post_rest, post_east, post_north, post_west, post_south,
        post_northeast, post_northwest, post_southwest, post_southeast,
        density, vel_x, vel_y,
        input  ready
    );
    modport sink (
        input  valid, post_rest, post_east, post_north, post_west, post_south,
        post_northeast, post_northwest, post_southwest, post_southeast,
        density, vel_x, vel_y,
        output ready
    );
endinterface

// File: src/d2q9_div.sv
module d2q9_div #(
    parameter int FRAC_BITS = d2q9_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         en,
    input  logic signed [d2q9_pkg::JW-1:0] mom,
    input  d2q9_pkg::word_t              rho,
    output d2q9_pkg::word_t              vel
);
    import d2q9_pkg::*;

    localparam int QW   = WORD_W;
    localparam int NW   = JW + FRAC_BITS + 2;
    localparam int MW   = NW - 1;
    localparam int REMW = 2 * WORD_W;
    localparam int CW   = (MW > REMW + 1) ? MW : REMW + 1;

    logic signed [NW-1:0] n_c;
    logic                 neg_c;
    logic [MW-1:0]        mag_c;
    logic [WORD_W-1:0]    dv_c;
    logic                 ovf_c;
    logic                 pos_c;

    logic [REMW-1:0]   rem_reg [0:QW];
    logic [WORD_W-1:0] d_reg   [0:QW];
    logic [QW-1:0]     q_reg   [0:QW];
    logic              neg_reg [0:QW];
    logic              ovf_reg [0:QW];
    logic              pos_reg [0:QW];
    word_t             vel_reg;
    word_t             vel_next;
    logic              big_c;

    // numerator 2*mom*one + rho, folded to a non-negative magnitude
    always_comb
    begin
        n_c   = (NW'(mom) <<< (FRAC_BITS + 1)) + NW'(rho);
        neg_c = n_c[NW-1];
        mag_c = neg_c ? ~n_c[MW-1:0] : n_c[MW-1:0];
        dv_c  = {rho[WORD_W-2:0], 1'b0};
        ovf_c = CW'(mag_c) >= (CW'(dv_c) << QW);
        pos_c = !rho[WORD_W-1] && (rho != '0);
    end

    // setup stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= REMW'(mag_c);
            d_reg[0]   <= dv_c;
            q_reg[0]   <= '0;
            neg_reg[0] <= neg_c;
            ovf_reg[0] <= ovf_c;
            pos_reg[0] <= pos_c;
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar s = 1; s <= QW; s++)
    begin : g_stage
        logic [REMW-1:0] trial;
        always_comb
            trial = REMW'(d_reg[s-1]) << (QW - s);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_reg[s-1] >= trial)
                begin
                    rem_reg[s] <= rem_reg[s-1] - trial;
                    q_reg[s]   <= q_reg[s-1] | (QW'(1) << (QW - s));
                end
                else
                begin
                    rem_reg[s] <= rem_reg[s-1];
                    q_reg[s]   <= q_reg[s-1];
                end
                d_reg[s]   <= d_reg[s-1];
                neg_reg[s] <= neg_reg[s-1];
                ovf_reg[s] <= ovf_reg[s-1];
                pos_reg[s] <= pos_reg[s-1];
            end
        end
    end

    // unfold the sign and saturate, zero when the density is not positive
    always_comb
    begin
        big_c = ovf_reg[QW] || q_reg[QW][QW-1];
        if (!pos_reg[QW])
            vel_next = '0;
        else if (big_c)
            vel_next = neg_reg[QW] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
        else if (neg_reg[QW])
            vel_next = ~{1'b0, q_reg[QW][QW-2:0]};
        else
            vel_next = {1'b0, q_reg[QW][QW-2:0]};
    end

    always_ff @(posedge clk)
    begin
        if (en)
            vel_reg <= vel_next;
    end

    assign vel = vel_reg;
endmodule

// File: src/d2q9_lane.sv
module d2q9_lane #(
    parameter int FRAC_BITS = d2q9_pkg::FRAC_BITS_DEF,
    parameter int DX        = 0,
    parameter int DY        = 0,
    parameter int WT_SHIFT  = 0
) (
    input  logic                              clk,
    input  logic                              en,
    input  d2q9_pkg::word_t                   ux,
    input  d2q9_pkg::word_t                   uy,
    input  logic [d2q9_pkg::UU_W-1:0]         uu,
    input  logic [d2q9_pkg::RATE_W-1:0]       rate,
    input  d2q9_pkg::word_t                   f,
    input  d2q9_pkg::word_t                   rho,
    output d2q9_pkg::word_t                   post
);
    import d2q9_pkg::*;

    localparam int EUW  = WORD_W + 2;
    localparam int PW   = (FRAC_BITS + 4 > 46 - FRAC_BITS) ? FRAC_BITS + 4 : 46 - FRAC_BITS;
    localparam int P2W  = PW + FRAC_BITS + 2;
    localparam int XW   = WORD_W + PW;
    localparam int AW   = XW + 6;
    localparam int BW   = AW - FRAC_BITS - 3;
    localparam int MW   = BW - 1;
    localparam int LO_W = MW / 2;
    localparam int HI_W = MW - LO_W;
    localparam int RW   = MW + 1;
    localparam int SH   = MW + 4;
    localparam int PPW  = MW + RW;
    localparam int QW   = PPW - SH;
    localparam int FW   = QW + 1;
    localparam int DW   = FW + 1;
    localparam int RPW  = DW + RATE_W + 1;
    localparam int RLW  = RPW - RATE_FRAC;
    localparam int SMW  = RLW + 1;
    localparam logic [RW-1:0] RCP = RW'(((64'd1 << SH) + 64'd8) / 64'd9);

    // delay lines for the population and density
    word_t f_d   [1:8];
    word_t rho_d [1:3];

    logic signed [EUW-1:0]   ex_c, ey_c;
    logic signed [EUW-1:0]   eu_reg, eu_d_reg;
    logic signed [2*EUW-1:0] eu2_reg;
    logic signed [P2W-1:0]   e_c, e6_c, e9_c, uu_c, u3_c, p2_c, pr_c;
    logic signed [PW-1:0]    p_reg;
    logic signed [XW-1:0]    x_reg;
    logic signed [AW-1:0]    a_c;
    logic signed [BW-1:0]    b_c;
    logic [MW-1:0]           m_c, m_reg;
    logic                    neg_c, neg_reg, neg_d_reg;
    logic [HI_W+RW-1:0]      ph_reg;
    logic [LO_W+RW-1:0]      pl_reg;
    logic [PPW-1:0]          pp_c;
    logic [QW-1:0]           q_c;
    logic signed [FW-1:0]    feq_c, feq_reg;
    logic signed [DW-1:0]    diff_c;
    logic signed [RPW-1:0]   rp_c, rp_reg;
    logic signed [RLW-1:0]   relax_c;
    logic signed [SMW-1:0]   sum_c;
    word_t                   post_reg;

    // projection of the velocity on this direction
    always_comb
    begin
        ex_c = (DX > 0) ? EUW'(ux) : ((DX < 0) ? -EUW'(ux) : '0);
        ey_c = (DY > 0) ? EUW'(uy) : ((DY < 0) ? -EUW'(uy) : '0);
    end

    // twice the equilibrium polynomial, then back to frac bits
    always_comb
    begin
        e_c  = P2W'(eu_d_reg);
        e6_c = (e_c <<< (FRAC_BITS + 2)) + (e_c <<< (FRAC_BITS + 1));
        e9_c = (P2W'(eu2_reg) <<< 3) + P2W'(eu2_reg);
        uu_c = signed'(P2W'(uu));
        u3_c = (uu_c <<< 1) + uu_c;
        p2_c = (P2W'(1) <<< (2 * FRAC_BITS + 1)) + e6_c + e9_c - u3_c;
        pr_c = (p2_c + (P2W'(1) <<< FRAC_BITS)) >>> (FRAC_BITS + 1);
    end

    // weight and the power-of-two part of the 1/36 scale
    always_comb
    begin
        a_c   = (AW'(x_reg) <<< (WT_SHIFT + 1)) + (AW'(9) <<< (FRAC_BITS + 2));
        b_c   = BW'(a_c >>> (FRAC_BITS + 3));
        neg_c = b_c[BW-1];
        m_c   = neg_c ? ~b_c[BW-2:0] : b_c[BW-2:0];
    end

    // divide by nine through the reciprocal
    always_comb
    begin
        pp_c  = (PPW'(ph_reg) << LO_W) + PPW'(pl_reg);
        q_c   = pp_c[PPW-1:SH];
        feq_c = neg_d_reg ? ~{1'b0, q_c} : {1'b0, q_c};
    end

    // relaxation toward equilibrium
    always_comb
    begin
        diff_c  = DW'(feq_reg) - DW'(f_d[7]);
        rp_c    = diff_c * signed'({1'b0, rate});
        relax_c = RLW'((rp_reg + (RPW'(1) <<< (RATE_FRAC - 1))) >>> RATE_FRAC);
        sum_c   = SMW'(relax_c) + SMW'(f_d[8]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_d[1]   <= f;
            for (int i = 2; i <= 8; i++)
                f_d[i] <= f_d[i-1];
            rho_d[1] <= rho;
            for (int i = 2; i <= 3; i++)
                rho_d[i] <= rho_d[i-1];
            eu_reg    <= ex_c + ey_c;
            eu_d_reg  <= eu_reg;
            eu2_reg   <= eu_reg * eu_reg;
            p_reg     <= pr_c[PW-1:0];
            x_reg     <= rho_d[3] * p_reg;
            m_reg     <= m_c;
            neg_reg   <= neg_c;
            ph_reg    <= m_reg[MW-1:LO_W] * RCP;
            pl_reg    <= m_reg[LO_W-1:0] * RCP;
            neg_d_reg <= neg_reg;
            feq_reg   <= feq_c;
            rp_reg    <= rp_c;
            post_reg  <= sat_word(64'(sum_c));
        end
    end

    assign post = post_reg;
endmodule

// File: src/d2q9_obuf.sv
module d2q9_obuf (
    input  logic                  clk,
    input  logic                  rst_n,
    input  d2q9_pkg::obuf_ctl_t   ctl,
    input  d2q9_pkg::out_item_t   din,
    output d2q9_pkg::out_item_t   dout,
    output d2q9_pkg::obuf_sts_t   sts
);
    import d2q9_pkg::*;

    logic [1:0] cnt_reg, cnt_next;
    out_item_t  e0_reg, e1_reg;

    // occupancy of the two-entry output stage
    always_comb
    begin
        cnt_next = cnt_reg;
        if (ctl.push && !ctl.take)
            cnt_next = cnt_reg + 2'd1;
        else if (ctl.take && !ctl.push)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    // load pushed items into the head entry or the spare entry
    always_ff @(posedge clk)
    begin
        if (ctl.take)
            e0_reg <= (ctl.push && cnt_reg == 2'd1) ? din : e1_reg;
        else if (ctl.push && cnt_reg == 2'd0)
            e0_reg <= din;
        if (ctl.push && ((cnt_reg == 2'd1 && !ctl.take) || (cnt_reg == 2'd2)))
            e1_reg <= din;
    end

    assign dout      = e0_reg;
    assign sts.full  = cnt_reg == 2'd2;
    assign sts.avail = cnt_reg != 2'd0;
endmodule

// File: src/d2q9_bgk_collision_node.sv
// d2q9 bgk collision, one lattice node per item
// an item passes the input registers, the divider (setup stage, one quotient bit per
// stage, output register) and the lanes before the output stage; an output stall holds it
// throughput: one item per cycle while the output is not stalled, every unit fully pipelined
// reset: relax_rate returns to 113620, pipeline and output stage empty
`include "assert_macros.svh"

module d2q9_bgk_collision_node #(
    parameter int FRAC_BITS = d2q9_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [d2q9_pkg::RATE_W-1:0]   cfg_data,
    d2q9_in_if.sink                       node_in,
    d2q9_out_if.source                    node_out
);
    import d2q9_pkg::*;

    localparam int VL = 1 + DIV_LAT + LANE_LAT;

    logic [RATE_W-1:0] relax_rate_reg;
    logic              vld_reg [0:VL-1];
    logic              en;

    word_t                 fin [NPOP];
    logic signed [SUM_W-1:0] sum_c;
    logic signed [JW-1:0]  jx_c, jy_c;

    word_t                 a_f_reg [NPOP];
    word_t                 a_rho_reg;
    logic signed [JW-1:0]  a_jx_reg, a_jy_reg;

    word_t                 fd_reg   [1:DIV_LAT][NPOP];
    word_t                 rhod_reg [1:DIV_LAT];
    word_t                 ux, uy;
    logic signed [UU_W-1:0] ux2_reg, uy2_reg;
    logic [UU_W-1:0]       uu_reg;
    word_t                 od_rho [1:LANE_LAT];
    word_t                 od_ux  [1:LANE_LAT];
    word_t                 od_uy  [1:LANE_LAT];
    word_t [NPOP-1:0]      post_w;

    obuf_ctl_t             ctl;
    obuf_sts_t             sts;
    out_item_t             merged, head;

    // rate register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            relax_rate_reg <= RATE_RESET;
        else if (cfg_we)
            relax_rate_reg <= cfg_data;
    end

    // pipeline moves unless the output stage is full, the output is not ready and a valid item waits at the end
    assign en            = !sts.full || node_out.ready || !vld_reg[VL-1];
    assign node_in.ready = en;

    // density and momentum
    always_comb
    begin
        fin[0] = node_in.pop_rest;
        fin[1] = node_in.pop_east;
        fin[2] = node_in.pop_north;
        fin[3] = node_in.pop_west;
        fin[4] = node_in.pop_south;
        fin[5] = node_in.pop_northeast;
        fin[6] = node_in.pop_northwest;
        fin[7] = node_in.pop_southwest;
        fin[8] = node_in.pop_southeast;
        sum_c = '0;
        for (int k = 0; k < NPOP; k++)
            sum_c = sum_c + SUM_W'(fin[k]);
        jx_c = JW'(fin[1]) + JW'(fin[5]) + JW'(fin[8])
             - JW'(fin[3]) - JW'(fin[6]) - JW'(fin[7]);
        jy_c = JW'(fin[2]) + JW'(fin[5]) + JW'(fin[6])
             - JW'(fin[4]) - JW'(fin[7]) - JW'(fin[8]);
    end

    // valid line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < VL; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= node_in.valid;
            for (int i = 1; i < VL; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    // payload lines alongside the divider and the lanes
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_f_reg   <= fin;
            a_rho_reg <= sat_word(64'(sum_c));
            a_jx_reg  <= jx_c;
            a_jy_reg  <= jy_c;
            fd_reg[1]   <= a_f_reg;
            rhod_reg[1] <= a_rho_reg;
            for (int i = 2; i <= DIV_LAT; i++)
            begin
                fd_reg[i]   <= fd_reg[i-1];
                rhod_reg[i] <= rhod_reg[i-1];
            end
            ux2_reg <= ux * ux;
            uy2_reg <= uy * uy;
            uu_reg  <= UU_W'(ux2_reg) + UU_W'(uy2_reg);
            od_rho[1] <= rhod_reg[DIV_LAT];
            od_ux[1]  <= ux;
            od_uy[1]  <= uy;
            for (int i = 2; i <= LANE_LAT; i++)
            begin
                od_rho[i] <= od_rho[i-1];
                od_ux[i]  <= od_ux[i-1];
                od_uy[i]  <= od_uy[i-1];
            end
        end
    end

    // velocity dividers
    d2q9_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
        .clk(clk), .en(en), .mom(a_jx_reg), .rho(a_rho_reg), .vel(ux)
    );
    d2q9_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
        .clk(clk), .en(en), .mom(a_jy_reg), .rho(a_rho_reg), .vel(uy)
    );

    // one collision lane per direction
    for (genvar k = 0; k < NPOP; k++)
    begin : g_lane
        d2q9_lane #(
            .FRAC_BITS(FRAC_BITS),
            .DX(DIR_X[k]),
            .DY(DIR_Y[k]),
            .WT_SHIFT(WT_SH[k])
        ) u_lane (
            .clk(clk),
            .en(en),
            .ux(ux),
            .uy(uy),
            .uu(uu_reg),
            .rate(relax_rate_reg),
            .f(fd_reg[DIV_LAT][k]),
            .rho(rhod_reg[DIV_LAT]),
            .post(post_w[k])
        );
    end

    // merge lane results with density and velocity
    always_comb
    begin
        merged.post    = post_w;
        merged.density = od_rho[LANE_LAT];
        merged.vel_x   = od_ux[LANE_LAT];
        merged.vel_y   = od_uy[LANE_LAT];
        ctl.push       = en && vld_reg[VL-1];
        ctl.take       = sts.avail && node_out.ready;
    end

    d2q9_obuf u_obuf (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .din(merged), .dout(head), .sts(sts)
    );

    // output item
    assign node_out.valid          = sts.avail;
    assign node_out.post_rest      = head.post[0];
    assign node_out.post_east      = head.post[1];
    assign node_out.post_north     = head.post[2];
    assign node_out.post_west      = head.post[3];
    assign node_out.post_south     = head.post[4];
    assign node_out.post_northeast = head.post[5];
    assign node_out.post_northwest = head.post[6];
    assign node_out.post_southwest = head.post[7];
    assign node_out.post_southeast = head.post[8];
    assign node_out.density        = head.density;
    assign node_out.vel_x          = head.vel_x;
    assign node_out.vel_y          = head.vel_y;

    // checks
    `ASSERT_AT(stall_only_when_backed_up, clk, rst_n, !node_in.ready |-> (node_out.valid && !node_out.ready))
    `ASSERT_AT(zero_vel_without_density, clk, rst_n, (node_out.valid && (node_out.density[WORD_W-1] || node_out.density == '0)) |-> (node_out.vel_x == '0 && node_out.vel_y == '0))
    `ASSERT_NEXT(accept_enters_pipe, clk, rst_n, node_in.valid && node_in.ready, vld_reg[0])
endmodule
